// ----- sv/pidpc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidpc_pkg
// Shared widths, register indexes, operation codes and helpers for the
// PID position controller.
// ----------------------------------------------------------------------------
package pidpc_pkg;

   localparam int POS_WIDTH       = 32;
   localparam int GAIN_WIDTH      = 32;
   localparam int SHORT_WIDTH     = 16;
   localparam int DIFF_WIDTH      = 33;
   localparam int INTEG_WIDTH     = 48;
   localparam int DERIV_WIDTH     = 48;
   localparam int MUL_A_WIDTH     = 48;
   localparam int MUL_B_WIDTH     = 32;
   localparam int MUL_CNT_WIDTH   = 5;
   localparam int PROD_WIDTH      = MUL_A_WIDTH + MUL_B_WIDTH;
   localparam int TERM_SHIFT      = 28;
   localparam int TERM_WIDTH      = PROD_WIDTH - TERM_SHIFT;
   localparam int SUM_WIDTH       = 56;
   localparam int DRIVE_WIDTH     = 17;
   localparam int REQ_DATA_WIDTH  = 64;
   localparam int RSP_DATA_WIDTH  = 24;
   localparam int RSP_USER_WIDTH  = 2;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 32;

   localparam logic [GAIN_WIDTH-1:0]  KP_GAIN_RESET   = 32'd368640000;
   localparam logic [GAIN_WIDTH-1:0]  KI_GAIN_RESET   = 32'd32768000;
   localparam logic [GAIN_WIDTH-1:0]  KD_GAIN_RESET   = 32'hFFC1_8000;
   localparam logic [SHORT_WIDTH-1:0] TIME_STEP_RESET = 16'd655;
   localparam logic [GAIN_WIDTH-1:0]  INV_STEP_RESET  = 32'd6553600;
   localparam logic [SHORT_WIDTH-1:0] DRIVE_LIM_RESET = 16'd10000;
   localparam logic [SHORT_WIDTH-1:0] TOLERANCE_RESET = 16'd66;

   localparam logic [INTEG_WIDTH-1:0] INTEG_MAX = {1'b0, {(INTEG_WIDTH-1){1'b1}}};
   localparam logic [INTEG_WIDTH-1:0] INTEG_MIN = {1'b1, {(INTEG_WIDTH-1){1'b0}}};
   localparam logic [POS_WIDTH-1:0]   POS_MAX   = {1'b0, {(POS_WIDTH-1){1'b1}}};
   localparam logic [POS_WIDTH-1:0]   POS_MIN   = {1'b1, {(POS_WIDTH-1){1'b0}}};

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_KP_GAIN   = 3'd0,
      CSR_KI_GAIN   = 3'd1,
      CSR_KD_GAIN   = 3'd2,
      CSR_TIME_STEP = 3'd3,
      CSR_INV_STEP  = 3'd4,
      CSR_DRIVE_LIM = 3'd5,
      CSR_TOLERANCE = 3'd6
   } csr_index_type;

   // products in the order they are formed
   typedef enum logic [2:0] {
      OP_INTEG      = 3'd0,
      OP_DERIV      = 3'd1,
      OP_PROP_TERM  = 3'd2,
      OP_INTEG_TERM = 3'd3,
      OP_DERIV_TERM = 3'd4
   } op_type;

   // magnitude of a two's complement word, as unsigned of the same width
   function automatic logic [GAIN_WIDTH-1:0] mag32(input logic [GAIN_WIDTH-1:0] v);
      mag32 = v[GAIN_WIDTH-1] ? (~v + 1'b1) : v;
   endfunction

endpackage

// ----- sv/pid_position_controller.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_position_controller
// Fixed-point PID position loop with symmetric output clamp.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one word holds target_pos and measured_pos (Q16.16) in tdata
//   and the restart flag in tuser. Restart clears the integral and the
//   previous error before the word is processed.
//   rsp channel: one word per request, the clamped drive in tdata and the
//   saturated / at_target flags in tuser.
//   csr channel: register writes by index, always ready; write only while no
//   request is in flight. Indexes past the register list are ignored.
// Datapath and request flow:
//   all products go through one bit-serial shift-add multiplier, one bit of
//   the 32-bit operand per cycle. Each of the five products passes through
//   S_LOAD, S_MUL and S_POST; S_ERR and S_DIFF come before them, S_OUT after.
//   rsp_tvalid and req_tready rise in the same cycle, when S_OUT loads the
//   result. One request is worked on at a time.
// Reset: synchronous, clears the integral, the previous error, all
//   handshakes, and loads the register defaults.
// Stall: a held result sits in the output register; the block still works
//   the next request and waits in S_OUT until rsp_tready frees the register.
// ----------------------------------------------------------------------------
module pid_position_controller (
   input  logic                                      clock,
   input  logic                                      reset,
   // req_tdata: target_pos [31:0], measured_pos [63:32]
   input  logic                                      req_tvalid,
   output logic                                      req_tready,
   input  logic [pidpc_pkg::REQ_DATA_WIDTH-1:0]      req_tdata,
   // req_tuser: restart
   input  logic                                      req_tuser,
   // rsp_tdata: drive [16:0], zero [23:17]
   output logic                                      rsp_tvalid,
   input  logic                                      rsp_tready,
   output logic [pidpc_pkg::RSP_DATA_WIDTH-1:0]      rsp_tdata,
   // rsp_tuser: saturated [0], at_target [1]
   output logic [pidpc_pkg::RSP_USER_WIDTH-1:0]      rsp_tuser,
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  logic [pidpc_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [pidpc_pkg::CSR_DATA_WIDTH-1:0]      csr_data
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_ERR,
      S_DIFF,
      S_LOAD,
      S_MUL,
      S_POST,
      S_OUT
   } state_type;

   localparam int PW = pidpc_pkg::POS_WIDTH;
   localparam int GW = pidpc_pkg::GAIN_WIDTH;
   localparam int SW = pidpc_pkg::SHORT_WIDTH;
   localparam int DW = pidpc_pkg::DIFF_WIDTH;
   localparam int IW = pidpc_pkg::INTEG_WIDTH;
   localparam int VW = pidpc_pkg::DERIV_WIDTH;
   localparam int AW = pidpc_pkg::MUL_A_WIDTH;
   localparam int BW = pidpc_pkg::MUL_B_WIDTH;
   localparam int CW = pidpc_pkg::MUL_CNT_WIDTH;
   localparam int QW = pidpc_pkg::PROD_WIDTH;
   localparam int TS = pidpc_pkg::TERM_SHIFT;
   localparam int TW = pidpc_pkg::TERM_WIDTH;
   localparam int UW = pidpc_pkg::SUM_WIDTH;
   localparam int RW = pidpc_pkg::DRIVE_WIDTH;

   state_type          state_ff, state_in;
   pidpc_pkg::op_type  op_ff, op_in;

   // configuration
   logic [GW-1:0] kp_ff, kp_in;
   logic [GW-1:0] ki_ff, ki_in;
   logic [GW-1:0] kd_ff, kd_in;
   logic [SW-1:0] dt_ff, dt_in;
   logic [GW-1:0] inv_dt_ff, inv_dt_in;
   logic [SW-1:0] lim_ff, lim_in;
   logic [SW-1:0] tol_ff, tol_in;

   // loop state
   logic [IW-1:0] integral_ff, integral_in;
   logic [PW-1:0] last_error_ff, last_error_in;

   // per-request working registers
   logic [PW-1:0] target_ff, target_in;
   logic [PW-1:0] measured_ff, measured_in;
   logic [PW-1:0] err_ff, err_in;
   logic [PW-1:0] err_mag_ff, err_mag_in;
   logic [DW-1:0] diff_ff, diff_in;
   logic [VW-1:0] deriv_mag_ff, deriv_mag_in;
   logic          deriv_neg_ff, deriv_neg_in;
   logic [UW-1:0] sum_ff, sum_in;

   // bit-serial multiplier
   logic [AW-1:0] mul_a_ff, mul_a_in;
   logic [BW-1:0] mul_b_ff, mul_b_in;
   logic [AW-1:0] acc_ff, acc_in;
   logic          mul_neg_ff, mul_neg_in;
   logic [CW-1:0] mul_cnt_ff, mul_cnt_in;

   // result register
   logic          rsp_tvalid_ff, rsp_tvalid_in;
   logic [RW-1:0] drive_ff, drive_in;
   logic          sat_ff, sat_in;
   logic          at_target_ff, at_target_in;

   logic          req_fire;
   logic          out_free;
   logic [DW-1:0] err_diff;
   logic [DW-1:0] diff_neg;
   logic [AW:0]   mul_step;
   logic [QW-1:0] prod;
   logic [PW-1:0] integ_inc;
   logic [IW:0]   integ_add;
   logic [IW-1:0] integral_mag;
   logic [UW-1:0] term_ext;
   logic [UW-1:0] lim_ext;
   logic [UW-1:0] neg_lim_ext;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid & req_tready;
   assign csr_ready  = 1'b1;
   assign out_free   = ~rsp_tvalid_ff | rsp_tready;

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {{(pidpc_pkg::RSP_DATA_WIDTH-RW){1'b0}}, drive_ff};
   assign rsp_tuser  = {at_target_ff, sat_ff};

   // shared arithmetic
   assign err_diff     = {target_ff[PW-1], target_ff} - {measured_ff[PW-1], measured_ff};
   assign diff_neg     = ~diff_ff + 1'b1;
   assign mul_step     = {1'b0, acc_ff} + (mul_b_ff[0] ? {1'b0, mul_a_ff} : '0);
   assign prod         = {acc_ff, mul_b_ff};
   assign integ_inc    = prod[PW+SW-1:SW];
   assign integ_add    = {integral_ff[IW-1], integral_ff}
                       + (mul_neg_ff ? ~{{(IW+1-PW){1'b0}}, integ_inc}
                                     :  {{(IW+1-PW){1'b0}}, integ_inc})
                       + {{IW{1'b0}}, mul_neg_ff};
   assign integral_mag = integral_ff[IW-1] ? (~integral_ff + 1'b1) : integral_ff;
   assign term_ext     = {{(UW-TW){1'b0}}, prod[QW-1:TS]};
   assign lim_ext      = {{(UW-SW){1'b0}}, lim_ff};
   assign neg_lim_ext  = ~lim_ext + 1'b1;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      kp_in         = kp_ff;
      ki_in         = ki_ff;
      kd_in         = kd_ff;
      dt_in         = dt_ff;
      inv_dt_in     = inv_dt_ff;
      lim_in        = lim_ff;
      tol_in        = tol_ff;
      integral_in   = integral_ff;
      last_error_in = last_error_ff;
      target_in     = target_ff;
      measured_in   = measured_ff;
      err_in        = err_ff;
      err_mag_in    = err_mag_ff;
      diff_in       = diff_ff;
      deriv_mag_in  = deriv_mag_ff;
      deriv_neg_in  = deriv_neg_ff;
      sum_in        = sum_ff;
      mul_a_in      = mul_a_ff;
      mul_b_in      = mul_b_ff;
      acc_in        = acc_ff;
      mul_neg_in    = mul_neg_ff;
      mul_cnt_in    = mul_cnt_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      drive_in      = drive_ff;
      sat_in        = sat_ff;
      at_target_in  = at_target_ff;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            pidpc_pkg::CSR_KP_GAIN:   kp_in     = csr_data;
            pidpc_pkg::CSR_KI_GAIN:   ki_in     = csr_data;
            pidpc_pkg::CSR_KD_GAIN:   kd_in     = csr_data;
            pidpc_pkg::CSR_TIME_STEP: dt_in     = csr_data[SW-1:0];
            pidpc_pkg::CSR_INV_STEP:  inv_dt_in = csr_data;
            pidpc_pkg::CSR_DRIVE_LIM: lim_in    = csr_data[SW-1:0];
            pidpc_pkg::CSR_TOLERANCE: tol_in    = csr_data[SW-1:0];
            default: ;
         endcase
      end

      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               target_in   = req_tdata[PW-1:0];
               measured_in = req_tdata[2*PW-1:PW];
               if (req_tuser) begin
                  integral_in   = '0;
                  last_error_in = '0;
               end
               state_in = S_ERR;
            end
         end
         S_ERR: begin
            if (err_diff[DW-1] != err_diff[DW-2]) begin
               err_in = err_diff[DW-1] ? pidpc_pkg::POS_MIN : pidpc_pkg::POS_MAX;
            end else begin
               err_in = err_diff[PW-1:0];
            end
            sum_in   = '0;
            op_in    = pidpc_pkg::OP_INTEG;
            state_in = S_DIFF;
         end
         S_DIFF: begin
            err_mag_in    = pidpc_pkg::mag32(err_ff);
            diff_in       = {err_ff[PW-1], err_ff} - {last_error_ff[PW-1], last_error_ff};
            last_error_in = err_ff;
            state_in      = S_LOAD;
         end
         S_LOAD: begin
            acc_in     = '0;
            mul_cnt_in = '0;
            case (op_ff)
               pidpc_pkg::OP_INTEG: begin
                  mul_a_in   = {{(AW-SW){1'b0}}, dt_ff};
                  mul_b_in   = err_mag_ff;
                  mul_neg_in = err_ff[PW-1];
               end
               pidpc_pkg::OP_DERIV: begin
                  mul_a_in   = {{(AW-GW){1'b0}}, inv_dt_ff};
                  mul_b_in   = diff_ff[DW-1] ? diff_neg[BW-1:0] : diff_ff[BW-1:0];
                  mul_neg_in = diff_ff[DW-1];
               end
               pidpc_pkg::OP_PROP_TERM: begin
                  mul_a_in   = {{(AW-PW){1'b0}}, err_mag_ff};
                  mul_b_in   = pidpc_pkg::mag32(kp_ff);
                  mul_neg_in = kp_ff[GW-1] ^ err_ff[PW-1];
               end
               pidpc_pkg::OP_INTEG_TERM: begin
                  mul_a_in   = integral_mag;
                  mul_b_in   = pidpc_pkg::mag32(ki_ff);
                  mul_neg_in = ki_ff[GW-1] ^ integral_ff[IW-1];
               end
               default: begin
                  mul_a_in   = deriv_mag_ff;
                  mul_b_in   = pidpc_pkg::mag32(kd_ff);
                  mul_neg_in = kd_ff[GW-1] ^ deriv_neg_ff;
               end
            endcase
            state_in = S_MUL;
         end
         S_MUL: begin
            // lsb-first shift-add, low product bits shift into the b register
            acc_in     = mul_step[AW:1];
            mul_b_in   = {mul_step[0], mul_b_ff[BW-1:1]};
            mul_cnt_in = mul_cnt_ff + 1'b1;
            if (mul_cnt_ff == CW'(BW - 1)) begin
               state_in = S_POST;
            end
         end
         S_POST: begin
            case (op_ff)
               pidpc_pkg::OP_INTEG: begin
                  if (integ_add[IW] != integ_add[IW-1]) begin
                     integral_in = integ_add[IW] ? pidpc_pkg::INTEG_MIN
                                                 : pidpc_pkg::INTEG_MAX;
                  end else begin
                     integral_in = integ_add[IW-1:0];
                  end
                  op_in    = pidpc_pkg::OP_DERIV;
                  state_in = S_LOAD;
               end
               pidpc_pkg::OP_DERIV: begin
                  deriv_mag_in = prod[VW+SW-1:SW];
                  deriv_neg_in = mul_neg_ff;
                  op_in        = pidpc_pkg::OP_PROP_TERM;
                  state_in     = S_LOAD;
               end
               pidpc_pkg::OP_PROP_TERM: begin
                  sum_in   = sum_ff + (mul_neg_ff ? ~term_ext : term_ext)
                           + {{(UW-1){1'b0}}, mul_neg_ff};
                  op_in    = pidpc_pkg::OP_INTEG_TERM;
                  state_in = S_LOAD;
               end
               pidpc_pkg::OP_INTEG_TERM: begin
                  sum_in   = sum_ff + (mul_neg_ff ? ~term_ext : term_ext)
                           + {{(UW-1){1'b0}}, mul_neg_ff};
                  op_in    = pidpc_pkg::OP_DERIV_TERM;
                  state_in = S_LOAD;
               end
               default: begin
                  sum_in   = sum_ff + (mul_neg_ff ? ~term_ext : term_ext)
                           + {{(UW-1){1'b0}}, mul_neg_ff};
                  state_in = S_OUT;
               end
            endcase
         end
         S_OUT: begin
            if (out_free) begin
               if ($signed(sum_ff) > $signed(lim_ext)) begin
                  drive_in = lim_ext[RW-1:0];
                  sat_in   = 1'b1;
               end else if ($signed(sum_ff) < $signed(neg_lim_ext)) begin
                  drive_in = neg_lim_ext[RW-1:0];
                  sat_in   = 1'b1;
               end else begin
                  drive_in = sum_ff[RW-1:0];
                  sat_in   = 1'b0;
               end
               at_target_in  = (err_mag_ff < {{(PW-SW){1'b0}}, tol_ff});
               rsp_tvalid_in = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         op_ff         <= pidpc_pkg::OP_INTEG;
         kp_ff         <= pidpc_pkg::KP_GAIN_RESET;
         ki_ff         <= pidpc_pkg::KI_GAIN_RESET;
         kd_ff         <= pidpc_pkg::KD_GAIN_RESET;
         dt_ff         <= pidpc_pkg::TIME_STEP_RESET;
         inv_dt_ff     <= pidpc_pkg::INV_STEP_RESET;
         lim_ff        <= pidpc_pkg::DRIVE_LIM_RESET;
         tol_ff        <= pidpc_pkg::TOLERANCE_RESET;
         integral_ff   <= '0;
         last_error_ff <= '0;
         mul_cnt_ff    <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         op_ff         <= op_in;
         kp_ff         <= kp_in;
         ki_ff         <= ki_in;
         kd_ff         <= kd_in;
         dt_ff         <= dt_in;
         inv_dt_ff     <= inv_dt_in;
         lim_ff        <= lim_in;
         tol_ff        <= tol_in;
         integral_ff   <= integral_in;
         last_error_ff <= last_error_in;
         mul_cnt_ff    <= mul_cnt_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      target_ff    <= target_in;
      measured_ff  <= measured_in;
      err_ff       <= err_in;
      err_mag_ff   <= err_mag_in;
      diff_ff      <= diff_in;
      deriv_mag_ff <= deriv_mag_in;
      deriv_neg_ff <= deriv_neg_in;
      sum_ff       <= sum_in;
      mul_a_ff     <= mul_a_in;
      mul_b_ff     <= mul_b_in;
      acc_ff       <= acc_in;
      mul_neg_ff   <= mul_neg_in;
      drive_ff     <= drive_in;
      sat_ff       <= sat_in;
      at_target_ff <= at_target_in;
   end

`ifndef SYNTHESIS
   // one request at a time
   a_single_request: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready)
      else $error("request taken while another is in flight");

   // restart clears the loop state before the error is formed
   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tuser) |=> (integral_ff == '0 && last_error_ff == '0))
      else $error("restart did not clear integral and previous error");

   // multiplier hands off after the last operand bit
   a_mul_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL && mul_cnt_ff == CW'(BW - 1)) |=> state_ff == S_POST)
      else $error("multiplier did not finish after last bit");

   // a finished result always lands in the output register
   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && out_free) |=> (rsp_tvalid_ff && state_ff == S_IDLE))
      else $error("result not loaded into output register");
`endif

endmodule
